// ===== hdl/mpdr_pkg.sv =====
package mpdr_pkg;

  localparam int unsigned SEEN_DEPTH_DEF = 5;
  localparam int unsigned ID_WIDTH_DEF   = 16;

  localparam int unsigned ADDR_W  = 16;
  localparam int unsigned DEPTH_W = 8;
  localparam int unsigned FLAGS_W = 8;
  localparam int unsigned WORD_W  = 2;
  localparam int unsigned ACT_W   = 4;

  localparam int unsigned PADDR_W = 3;
  localparam int unsigned PDATA_W = 32;

  localparam logic [ADDR_W-1:0] ADDR_BROADCAST = 16'd0;
  localparam logic [ADDR_W-1:0] ADDR_APP       = 16'd5;
  localparam logic [ADDR_W-1:0] LOCAL_ADDR_RST = 16'd1;

  localparam logic [FLAGS_W-1:0] FLG_DISC    = 8'h01;
  localparam logic [FLAGS_W-1:0] FLG_ACK     = 8'h04;
  localparam logic [FLAGS_W-1:0] FLG_ENC     = 8'h08;
  localparam logic [FLAGS_W-1:0] FLG_DEFINED = 8'h0F;

  localparam logic [WORD_W-1:0] WORD_NEWS  = 2'd1;
  localparam logic [WORD_W-1:0] WORD_MUSIC = 2'd2;

  localparam logic [DEPTH_W-1:0] REPLY_DEPTH = 8'd1;

  localparam logic [0:0] REG_LOCAL_ADDR = 1'b0;

  typedef enum logic [ACT_W-1:0] {
    ACT_DUP     = 4'd0,
    ACT_RELAY   = 4'd1,
    ACT_EXPIRED = 4'd2,
    ACT_ENC     = 4'd3,
    ACT_PEER    = 4'd4,
    ACT_REPLY   = 4'd5,
    ACT_APP     = 4'd6,
    ACT_MUSIC   = 4'd7,
    ACT_DELIVER = 4'd8,
    ACT_IGNORE  = 4'd9
  } action_t;

endpackage

// ===== hdl/mpdr_ifs.sv =====
interface mpdr_in_if import mpdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [15:0]        message_id;
  logic [ADDR_W-1:0]  destination;
  logic [ADDR_W-1:0]  src_addr;
  logic [DEPTH_W-1:0] hop_depth;
  logic [FLAGS_W-1:0] flag_bits;
  logic [WORD_W-1:0]  app_word;

  modport source (
    output valid, message_id, destination, src_addr, hop_depth, flag_bits, app_word,
    input  ready
  );
  modport sink (
    input  valid, message_id, destination, src_addr, hop_depth, flag_bits, app_word,
    output ready
  );
endinterface

interface mpdr_out_if import mpdr_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [ACT_W-1:0]   action;
  logic [ADDR_W-1:0]  out_destination;
  logic [ADDR_W-1:0]  out_source;
  logic [DEPTH_W-1:0] out_depth;
  logic [FLAGS_W-1:0] out_flags;

  modport source (
    output valid, action, out_destination, out_source, out_depth, out_flags,
    input  ready
  );
  modport sink (
    input  valid, action, out_destination, out_source, out_depth, out_flags,
    output ready
  );
endinterface

// ===== hdl/mesh_packet_dedup_router.sv =====
// mesh packet dedup router
// in_if takes one received packet header per item (valid/ready); out_if gives
// exactly one result item per input item: an action code plus, for relay and
// discovery reply, the header to transmit (other fields are zero).
// the header is checked against a ring of SEEN_DEPTH recent message ids and
// classified in the cycle it is accepted; the result appears in the output
// register on the next cycle.
// throughput is one item per cycle unless the receiver stalls: the id ring
// is updated at the accepting edge, so the next item already sees it.
// when the receiver stalls, the result is held in the output register and
// in_if.ready drops until it is taken; a new item is taken in the same cycle
// the held result leaves.
// the apb port holds local_address at byte address 0 (reset value 1); write it
// only while no item is in flight.
// reset (rst_n low, synchronous) clears the ring valid bits, the ring pointer
// and the output valid, and sets local_address to 1.
module mesh_packet_dedup_router
  import mpdr_pkg::*;
#(
  parameter int unsigned SEEN_DEPTH = SEEN_DEPTH_DEF,
  parameter int unsigned ID_WIDTH   = ID_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  mpdr_in_if.sink            in_if,
  mpdr_out_if.source         out_if,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready
);

  localparam int unsigned PTR_W = (SEEN_DEPTH > 1) ? $clog2(SEEN_DEPTH) : 1;

  logic [ID_WIDTH-1:0]   seen_ids_r [SEEN_DEPTH];
  logic [SEEN_DEPTH-1:0] seen_vld_r;
  logic [PTR_W-1:0]      ptr_r, ptr_nxt;
  logic [ADDR_W-1:0]     local_addr_r;

  logic               out_valid_r;
  action_t            action_r, action_nxt;
  logic [ADDR_W-1:0]  odst_r, odst_nxt;
  logic [ADDR_W-1:0]  osrc_r, osrc_nxt;
  logic [DEPTH_W-1:0] odep_r, odep_nxt;
  logic [FLAGS_W-1:0] ofl_r, ofl_nxt;

  logic                   in_fire;
  logic [ID_WIDTH+15:0]   id_ext;
  logic [ID_WIDTH-1:0]    id_w;
  logic [SEEN_DEPTH-1:0]  match;
  logic                   hit;
  logic                   cfg_wr;
  logic                   disc, ack, enc, to_other, to_app;

  assign in_if.ready = !out_valid_r || out_if.ready;
  assign in_fire     = in_if.valid && in_if.ready;

  assign id_ext = {{ID_WIDTH{1'b0}}, in_if.message_id};
  assign id_w   = id_ext[ID_WIDTH-1:0];

  always_comb begin
    for (int i = 0; i < SEEN_DEPTH; i++) begin
      match[i] = seen_vld_r[i] && (seen_ids_r[i] == id_w);
    end
  end
  assign hit = |match;

  assign ptr_nxt = (ptr_r == PTR_W'(SEEN_DEPTH - 1)) ? '0 : ptr_r + 1'b1;

  assign disc     = |(in_if.flag_bits & FLG_DISC);
  assign ack      = |(in_if.flag_bits & FLG_ACK);
  assign enc      = |(in_if.flag_bits & FLG_ENC);
  assign to_app   = in_if.destination == ADDR_APP;
  assign to_other = (in_if.destination != ADDR_BROADCAST) && !to_app &&
                    (in_if.destination != local_addr_r);

  always_comb begin
    action_nxt = ACT_IGNORE;
    odst_nxt   = '0;
    osrc_nxt   = '0;
    odep_nxt   = '0;
    ofl_nxt    = '0;
    priority if (hit) begin
      action_nxt = ACT_DUP;
    end else if (to_other) begin
      if (in_if.hop_depth > DEPTH_W'(1)) begin
        action_nxt = ACT_RELAY;
        odst_nxt   = in_if.destination;
        osrc_nxt   = in_if.src_addr;
        odep_nxt   = in_if.hop_depth - 1'b1;
        ofl_nxt    = in_if.flag_bits & FLG_DEFINED;
      end else begin
        action_nxt = ACT_EXPIRED;
      end
    end else if (enc) begin
      action_nxt = ACT_ENC;
    end else if (disc && ack) begin
      action_nxt = ACT_PEER;
    end else if (disc) begin
      action_nxt = ACT_REPLY;
      odst_nxt   = in_if.src_addr;
      osrc_nxt   = local_addr_r;
      odep_nxt   = REPLY_DEPTH;
      ofl_nxt    = FLG_ACK | FLG_DISC;
    end else if (to_app && in_if.app_word == WORD_NEWS) begin
      action_nxt = ACT_APP;
    end else if (to_app && in_if.app_word == WORD_MUSIC) begin
      action_nxt = ACT_MUSIC;
    end else if (in_if.destination == local_addr_r) begin
      action_nxt = ACT_DELIVER;
    end else begin
      action_nxt = ACT_IGNORE;
    end
  end

  // id ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_vld_r <= '0;
      ptr_r      <= '0;
    end else if (in_fire && !hit) begin
      seen_vld_r[ptr_r] <= 1'b1;
      ptr_r             <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire && !hit) begin
      seen_ids_r[ptr_r] <= id_w;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      out_valid_r <= in_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      action_r <= action_nxt;
      odst_r   <= odst_nxt;
      osrc_r   <= osrc_nxt;
      odep_r   <= odep_nxt;
      ofl_r    <= ofl_nxt;
    end
  end

  assign out_if.valid           = out_valid_r;
  assign out_if.action          = action_r;
  assign out_if.out_destination = odst_r;
  assign out_if.out_source      = osrc_r;
  assign out_if.out_depth       = odep_r;
  assign out_if.out_flags       = ofl_r;

  // configuration
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_LOCAL_ADDR);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_addr_r <= LOCAL_ADDR_RST;
    end else if (cfg_wr) begin
      local_addr_r <= pwdata[ADDR_W-1:0];
    end
  end

  assign prdata = (paddr[2] == REG_LOCAL_ADDR) ?
                  {{(PDATA_W-ADDR_W){1'b0}}, local_addr_r} : '0;

`ifndef SYNTH
  a_dup_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && hit |=> out_if.action == ACT_DUP)
    else $error("repeated id not reported as duplicate");

  a_ring_write: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && !hit |=> seen_vld_r[$past(ptr_r)] && seen_ids_r[$past(ptr_r)] == $past(id_w))
    else $error("new id not stored in ring");

  a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
    ptr_r <= PTR_W'(SEEN_DEPTH - 1))
    else $error("ring pointer out of range");

  a_ring_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_fire && !hit) |=> $stable(ptr_r) && $stable(seen_vld_r))
    else $error("ring changed without a new id");

  a_zero_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && (action_r != ACT_RELAY) && (action_r != ACT_REPLY)
    |-> (odst_r == '0) && (osrc_r == '0) && (odep_r == '0) && (ofl_r == '0))
    else $error("unused result fields not zero");
`endif

endmodule
